/* hw/rtl/sast_pkg.sv */
`default_nettype none

package sast_pkg;

   localparam int unsigned DEPTH_DEFAULT     = 1024;
   localparam int unsigned ADDR_BITS_DEFAULT = 48;
   localparam int unsigned STATUS_W          = 3;
   localparam int unsigned OPCODE_W          = 2;

   // OR levels between two register ranks in the hit tree
   localparam int unsigned TREE_SPAN = 4;

   typedef enum logic [OPCODE_W-1:0] {
      OP_INSERT  = 2'd0,
      OP_REMOVE  = 2'd1,
      OP_CHECK   = 2'd2,
      OP_REPLACE = 2'd3
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 3'd0,
      STAT_DUP     = 3'd1,
      STAT_MISSING = 3'd2,
      STAT_FULL    = 3'd3,
      STAT_ZERO    = 3'd4
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK_OLD,
      S_LOOK_NEW,
      S_DELETE,
      S_INSERT,
      S_REPLY
   } state_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
   } cell_ctrl_type;

   // register ranks on the path from the leaves to the root of the hit tree
   function automatic int unsigned tree_stages(input int unsigned leaves);
      int unsigned levels;
      levels = $clog2(leaves);
      return levels / TREE_SPAN;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/sast_if.sv */
`default_nettype none

interface sast_req_if #(
   parameter int unsigned ADDR_BITS = sast_pkg::ADDR_BITS_DEFAULT
);
   logic                          valid;
   logic                          ready;
   logic [sast_pkg::OPCODE_W-1:0] opcode;
   logic [ADDR_BITS-1:0]          address;
   logic [ADDR_BITS-1:0]          new_address;

   modport source (output valid, output opcode, output address, output new_address,
                   input ready);
   modport sink   (input valid, input opcode, input address, input new_address,
                   output ready);
endinterface

interface sast_rsp_if #(
   parameter int unsigned COUNT_W = $clog2(sast_pkg::DEPTH_DEFAULT + 1)
);
   logic                          valid;
   logic                          ready;
   logic [sast_pkg::STATUS_W-1:0] status;
   logic [COUNT_W-1:0]            live_count;

   modport source (output valid, output status, output live_count, input ready);
   modport sink   (input valid, input status, input live_count, output ready);
endinterface

`default_nettype wire

/* hw/rtl/sorted_address_set_tracker.sv */
`default_nettype none
// Channel  Dir  Handshake      Payload
// req_ch   in   valid/ready    opcode, address, new_address
// rsp_ch   out  valid/ready    status, live_count
//
// Each request runs from accept to the response register through L lookups (0 to 2)
// and S chain shifts (0 to 2); no new request is taken until the response register
// is loaded and the block is back in idle. The lookup wait is set by the hit
// reduction tree, one register rank per four OR levels.
// Reset clears the count and control; table contents stay undefined.
// A held response stalls the final hand-over, and the request port stays closed until it is done.

module sorted_address_set_tracker #(
   parameter int unsigned DEPTH     = sast_pkg::DEPTH_DEFAULT,
   parameter int unsigned ADDR_BITS = sast_pkg::ADDR_BITS_DEFAULT
) (
   input  wire         clock,
   input  wire         reset,
   sast_req_if.sink    req_ch,
   sast_rsp_if.source  rsp_ch
);

   localparam int unsigned COUNT_W     = $clog2(DEPTH + 1);
   localparam int unsigned TREE_STAGES = sast_pkg::tree_stages(DEPTH);
   localparam int unsigned WAIT_LAST   = TREE_STAGES + 1;
   localparam int unsigned WAIT_W      = $clog2(WAIT_LAST + 1);

   sast_pkg::state_type   state_ff, state_in;
   sast_pkg::opcode_type  op_ff, op_in;
   sast_pkg::status_type  status_ff, status_in;
   logic [ADDR_BITS-1:0]  old_ff, old_in;
   logic [ADDR_BITS-1:0]  new_ff, new_in;
   logic [ADDR_BITS-1:0]  key_ff, key_in;
   logic [COUNT_W-1:0]    count_ff, count_in;
   logic [WAIT_W-1:0]     wait_ff, wait_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [sast_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [COUNT_W-1:0]    rsp_count_ff;
   logic                  rsp_load_w;
   logic                  accept_w;
   logic                  found_w;
   logic                  full_w;
   sast_pkg::cell_ctrl_type cell_ctrl_w;

   logic [ADDR_BITS-1:0]  entry_w [DEPTH];
   logic [DEPTH-1:0]      below_w;
   logic [DEPTH-1:0]      hit_w;

   genvar i;

   for (i = 0; i < DEPTH; i++) begin : g_cell
      logic [ADDR_BITS-1:0] left_entry_w;
      logic                 left_below_w;
      logic [ADDR_BITS-1:0] right_entry_w;

      // zero sentinel ahead of the first cell, below every nonzero key
      if (i == 0) begin : g_first
         assign left_entry_w = '0;
         assign left_below_w = 1'b1;
      end else begin : g_mid
         assign left_entry_w = entry_w[i-1];
         assign left_below_w = below_w[i-1];
      end

      if (i == DEPTH - 1) begin : g_last
         assign right_entry_w = entry_w[i];
      end else begin : g_inner
         assign right_entry_w = entry_w[i+1];
      end

      sast_cell #(
         .INDEX     (i),
         .ADDR_BITS (ADDR_BITS),
         .COUNT_W   (COUNT_W)
      ) u_cell (
         .clock       (clock),
         .ctrl        (cell_ctrl_w),
         .count       (count_ff),
         .key         (key_ff),
         .left_entry  (left_entry_w),
         .left_below  (left_below_w),
         .right_entry (right_entry_w),
         .entry       (entry_w[i]),
         .below       (below_w[i]),
         .hit         (hit_w[i])
      );
   end

   sast_or_tree #(
      .LEAVES (DEPTH)
   ) u_tree (
      .clock (clock),
      .leaf  (hit_w),
      .root  (found_w)
   );

   assign req_ch.ready = (state_ff == sast_pkg::S_IDLE);
   assign accept_w     = req_ch.valid && req_ch.ready;
   assign full_w       = (count_ff == COUNT_W'(DEPTH));

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      old_in         = old_ff;
      new_in         = new_ff;
      key_in         = key_ff;
      status_in      = status_ff;
      count_in       = count_ff;
      wait_in        = '0;
      cell_ctrl_w.op = sast_pkg::CELL_HOLD;
      rsp_load_w     = 1'b0;
      rsp_valid_in   = rsp_valid_ff && !rsp_ch.ready;

      case (state_ff)
         sast_pkg::S_IDLE: begin
            if (accept_w) begin
               op_in  = sast_pkg::opcode_type'(req_ch.opcode);
               old_in = req_ch.address;
               new_in = req_ch.new_address;
               if (req_ch.address != '0) begin
                  key_in   = req_ch.address;
                  state_in = sast_pkg::S_LOOK_OLD;
               end else if (sast_pkg::opcode_type'(req_ch.opcode) != sast_pkg::OP_REPLACE ||
                            req_ch.new_address == '0) begin
                  status_in = sast_pkg::STAT_ZERO;
                  state_in  = sast_pkg::S_REPLY;
               end else begin
                  key_in   = req_ch.new_address;
                  state_in = sast_pkg::S_LOOK_NEW;
               end
            end
         end
         sast_pkg::S_LOOK_OLD: begin
            if (wait_ff != WAIT_W'(WAIT_LAST)) begin
               wait_in = wait_ff + WAIT_W'(1);
            end else begin
               state_in = sast_pkg::S_REPLY;
               case (op_ff)
                  sast_pkg::OP_INSERT: begin
                     if (found_w) begin
                        status_in = sast_pkg::STAT_DUP;
                     end else if (full_w) begin
                        status_in = sast_pkg::STAT_FULL;
                     end else begin
                        status_in = sast_pkg::STAT_OK;
                        state_in  = sast_pkg::S_INSERT;
                     end
                  end
                  sast_pkg::OP_REMOVE: begin
                     if (found_w) begin
                        status_in = sast_pkg::STAT_OK;
                        state_in  = sast_pkg::S_DELETE;
                     end else begin
                        status_in = sast_pkg::STAT_MISSING;
                     end
                  end
                  sast_pkg::OP_CHECK: begin
                     status_in = found_w ? sast_pkg::STAT_OK : sast_pkg::STAT_MISSING;
                  end
                  default: begin
                     if (!found_w) begin
                        status_in = sast_pkg::STAT_MISSING;
                     end else if (new_ff == '0) begin
                        status_in = sast_pkg::STAT_ZERO;
                     end else if (new_ff == old_ff) begin
                        status_in = sast_pkg::STAT_OK;
                     end else begin
                        key_in   = new_ff;
                        state_in = sast_pkg::S_LOOK_NEW;
                     end
                  end
               endcase
            end
         end
         sast_pkg::S_LOOK_NEW: begin
            if (wait_ff != WAIT_W'(WAIT_LAST)) begin
               wait_in = wait_ff + WAIT_W'(1);
            end else if (found_w) begin
               status_in = sast_pkg::STAT_DUP;
               state_in  = sast_pkg::S_REPLY;
            end else if (old_ff == '0 && full_w) begin
               status_in = sast_pkg::STAT_FULL;
               state_in  = sast_pkg::S_REPLY;
            end else if (old_ff != '0) begin
               status_in = sast_pkg::STAT_OK;
               key_in    = old_ff;
               state_in  = sast_pkg::S_DELETE;
            end else begin
               status_in = sast_pkg::STAT_OK;
               state_in  = sast_pkg::S_INSERT;
            end
         end
         sast_pkg::S_DELETE: begin
            cell_ctrl_w.op = sast_pkg::CELL_DELETE;
            count_in       = count_ff - COUNT_W'(1);
            if (op_ff == sast_pkg::OP_REPLACE) begin
               key_in   = new_ff;
               state_in = sast_pkg::S_INSERT;
            end else begin
               state_in = sast_pkg::S_REPLY;
            end
         end
         sast_pkg::S_INSERT: begin
            cell_ctrl_w.op = sast_pkg::CELL_INSERT;
            count_in       = count_ff + COUNT_W'(1);
            state_in       = sast_pkg::S_REPLY;
         end
         sast_pkg::S_REPLY: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_load_w   = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = sast_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = sast_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sast_pkg::S_IDLE;
         count_ff     <= '0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff     <= op_in;
      old_ff    <= old_in;
      new_ff    <= new_in;
      key_ff    <= key_in;
      status_ff <= status_in;
      if (rsp_load_w) begin
         rsp_status_ff <= status_ff;
         rsp_count_ff  <= count_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.status     = rsp_status_ff;
   assign rsp_ch.live_count = rsp_count_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_W'(DEPTH))
      else $error("live count beyond table depth");

   a_insert_room: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sast_pkg::S_INSERT) |-> !full_w)
      else $error("insert shift into a full chain");

   a_delete_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sast_pkg::S_DELETE) |-> (count_ff != '0))
      else $error("delete shift on an empty chain");

   a_delete_after_lookup: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sast_pkg::S_DELETE) |->
         ($past(state_ff) == sast_pkg::S_LOOK_OLD || $past(state_ff) == sast_pkg::S_LOOK_NEW))
      else $error("delete shift without a completed lookup");

   a_rsp_from_reply: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == sast_pkg::S_REPLY))
      else $error("response raised outside the reply state");

endmodule

`default_nettype wire

/* hw/rtl/sast_cell.sv */
`default_nettype none

module sast_cell #(
   parameter int unsigned INDEX     = 0,
   parameter int unsigned ADDR_BITS = sast_pkg::ADDR_BITS_DEFAULT,
   parameter int unsigned COUNT_W   = $clog2(sast_pkg::DEPTH_DEFAULT + 1)
) (
   input  wire                          clock,
   input  sast_pkg::cell_ctrl_type      ctrl,
   input  wire [COUNT_W-1:0]            count,
   input  wire [ADDR_BITS-1:0]          key,
   input  wire [ADDR_BITS-1:0]          left_entry,
   input  wire                          left_below,
   input  wire [ADDR_BITS-1:0]          right_entry,
   output logic [ADDR_BITS-1:0]         entry,
   output logic                         below,
   output logic                         hit
);

   logic [ADDR_BITS-1:0] entry_ff;
   logic [ADDR_BITS-1:0] entry_in;
   logic                 hit_ff;
   logic                 live_w;

   assign live_w = (count > COUNT_W'(INDEX));
   assign below  = live_w && (entry_ff < key);

   always_comb begin
      entry_in = entry_ff;
      case (ctrl.op)
         sast_pkg::CELL_INSERT: begin
            if (!below) begin
               entry_in = left_below ? key : left_entry;
            end
         end
         sast_pkg::CELL_DELETE: begin
            if (!below) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      hit_ff   <= live_w && (entry_ff == key);
   end

   assign entry = entry_ff;
   assign hit   = hit_ff;

endmodule

`default_nettype wire

/* hw/rtl/sast_or_tree.sv */
`default_nettype none

module sast_or_tree #(
   parameter int unsigned LEAVES = sast_pkg::DEPTH_DEFAULT
) (
   input  wire              clock,
   input  wire [LEAVES-1:0] leaf,
   output logic             root
);

   localparam int unsigned LOG_P = $clog2(LEAVES);
   localparam int unsigned P     = 1 << LOG_P;

   // heap order: node n has children 2n and 2n+1, leaves from P upwards
   logic [2*P-1:1] node_w;

   genvar j, n;

   for (j = 0; j < P; j++) begin : g_leaf
      if (j < LEAVES) begin : g_used
         assign node_w[P+j] = leaf[j];
      end else begin : g_pad
         assign node_w[P+j] = 1'b0;
      end
   end

   for (n = 1; n < P; n++) begin : g_node
      localparam int unsigned HEIGHT = LOG_P - ($clog2(n + 1) - 1);
      if ((HEIGHT % sast_pkg::TREE_SPAN) == 0) begin : g_reg
         logic hold_ff;
         always_ff @(posedge clock) begin
            hold_ff <= node_w[2*n] | node_w[2*n+1];
         end
         assign node_w[n] = hold_ff;
      end else begin : g_comb
         assign node_w[n] = node_w[2*n] | node_w[2*n+1];
      end
   end

   assign root = node_w[1];

endmodule

`default_nettype wire
